>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths and fixed codes shared by the cache, its channels and checker.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

endpackage

>>> rtl/lkv_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// One get or set operation per beat.
// ----------------------------------------------------------------------------
interface lkv_req_if import lkv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  lookup_key;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output func, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input func, input lookup_key, input write_value,
                  output ready);
endinterface

>>> rtl/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// One result beat per accepted request.
// ----------------------------------------------------------------------------
interface lkv_rsp_if import lkv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
  logic [KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

>>> rtl/lkv_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Writes the capacity register, one beat per write.
// ----------------------------------------------------------------------------
interface lkv_cfg_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] cache_capacity;

  modport source (output valid, output cache_capacity, input ready);
  modport sink   (input valid, input cache_capacity, output ready);
endinterface

>>> rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative cache with a recency rank per slot, searched and updated
// one slot at a time through a single compare and increment unit.
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  req      in         func, lookup_key, write_value
//  rsp      out        hit, read_value, evicted, evicted_key
//  cfg      in         cache_capacity
//
//  The result beat is registered after a search pass over the used slots and,
//  for a hit or a set, a rank pass over them, one slot at a time on the single
//  read port of each slot memory. req.ready rises on the same edge that
//  registers the result beat, so one item is worked on at a time.
//  cfg.ready is always high.
//  A waiting result beat stalls the next item only in the FINISH state.
//  Reset empties the cache and sets the capacity to 16; there is no clearing
//  pass, since only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input logic      clk,
  input logic      rst,
  lkv_req_if.sink  req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink  cfg
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    IDLE, SCAN_RD, SCAN_CMP, DECIDE, UPD_RD, UPD_WR, FINISH
  } state_t;

  state_t            state;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     used_count;
  logic [CAP_W-1:0]  capacity;

  logic              op_set;
  logic [KEY_W-1:0]  op_key;
  logic [DATA_W-1:0] op_value;

  logic              found;
  logic [AW-1:0]     found_slot;
  logic [AW-1:0]     found_rank;
  logic [DATA_W-1:0] found_value;
  logic [AW-1:0]     victim_slot;
  logic [KEY_W-1:0]  victim_key;

  logic [CW-1:0]     thr;
  logic [AW-1:0]     target;
  logic              do_kv;
  logic              do_key;
  logic              do_rank;
  logic              do_fill;

  logic              res_hit;
  logic [DATA_W-1:0] res_value;
  logic              res_evicted;
  logic [KEY_W-1:0]  res_evkey;

  logic              out_valid;
  logic              out_hit;
  logic [DATA_W-1:0] out_value;
  logic              out_evicted;
  logic [KEY_W-1:0]  out_evkey;

  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] value_q;
  logic [AW-1:0]     rank_q;

  logic              key_we;
  logic              value_we;
  logic              rank_we;
  logic [AW-1:0]     rank_waddr;
  logic [AW-1:0]     rank_wdata;
  logic [AW-1:0]     raddr;

  logic [XW-1:0]     cap_x;
  logic [XW-1:0]     eff_cap;
  logic              has_room;
  logic              last_slot;
  logic              fin_fire;

  assign req.ready = (state == IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.read_value  = out_value;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_evkey;

  // Capacity zero acts as one, and anything above the slot count saturates.
  assign cap_x    = XW'(capacity);
  assign eff_cap  = (cap_x == '0) ? XW'(1) :
                    ((cap_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cap_x);
  assign has_room = XW'(used_count) < eff_cap;

  assign last_slot = (idx + CW'(1)) == used_count;
  assign fin_fire  = (state == FINISH) && (!out_valid || rsp.ready);
  assign raddr     = idx[AW-1:0];

  assign key_we   = fin_fire && do_key;
  assign value_we = fin_fire && do_kv;

  always_comb begin
    if (state == UPD_WR) begin
      rank_we    = CW'(rank_q) < thr;
      rank_waddr = idx[AW-1:0];
      rank_wdata = rank_q + AW'(1);
    end else begin
      rank_we    = fin_fire && do_rank;
      rank_waddr = target;
      rank_wdata = '0;
    end
  end

  lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (target),
    .wdata (op_key),
    .raddr (raddr),
    .rdata (key_q)
  );

  lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (target),
    .wdata (op_value),
    .raddr (raddr),
    .rdata (value_q)
  );

  lkv_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (raddr),
    .rdata (rank_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      used_count <= '0;
      capacity   <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.cache_capacity;
      end
      if (out_valid && rsp.ready && !fin_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (req.valid) begin
            op_set   <= req.func;
            op_key   <= req.lookup_key;
            op_value <= req.write_value;
            found    <= 1'b0;
            idx      <= '0;
            state    <= (used_count == '0) ? DECIDE : SCAN_RD;
          end
        end

        SCAN_RD: begin
          state <= SCAN_CMP;
        end

        SCAN_CMP: begin
          if (!found && key_q == op_key) begin
            found       <= 1'b1;
            found_slot  <= idx[AW-1:0];
            found_rank  <= rank_q;
            found_value <= value_q;
          end
          // The least recent slot holds the highest rank in use.
          if (CW'(rank_q) == used_count - CW'(1)) begin
            victim_slot <= idx[AW-1:0];
            victim_key  <= key_q;
          end
          idx   <= idx + CW'(1);
          state <= last_slot ? DECIDE : SCAN_RD;
        end

        DECIDE: begin
          res_hit   <= found;
          res_value <= (found && op_set == FUNC_GET) ? found_value : MISS_VALUE;
          if (found) begin
            res_evicted <= 1'b0;
            res_evkey   <= '0;
            thr         <= CW'(found_rank);
            target      <= found_slot;
            do_rank     <= 1'b1;
            do_kv       <= op_set;
            do_key      <= 1'b0;
            do_fill     <= 1'b0;
          end else if (op_set == FUNC_SET && has_room) begin
            // Every used rank is below the fill count, so all of them age.
            res_evicted <= 1'b0;
            res_evkey   <= '0;
            thr         <= used_count;
            target      <= used_count[AW-1:0];
            do_rank     <= 1'b1;
            do_kv       <= 1'b1;
            do_key      <= 1'b1;
            do_fill     <= 1'b1;
          end else if (op_set == FUNC_SET) begin
            res_evicted <= 1'b1;
            res_evkey   <= victim_key;
            thr         <= used_count - CW'(1);
            target      <= victim_slot;
            do_rank     <= 1'b1;
            do_kv       <= 1'b1;
            do_key      <= 1'b1;
            do_fill     <= 1'b0;
          end else begin
            res_evicted <= 1'b0;
            res_evkey   <= '0;
            thr         <= used_count - CW'(1);
            target      <= victim_slot;
            do_rank     <= 1'b0;
            do_kv       <= 1'b0;
            do_key      <= 1'b0;
            do_fill     <= 1'b0;
          end
          idx   <= '0;
          state <= ((found || op_set == FUNC_SET) && used_count != '0) ? UPD_RD : FINISH;
        end

        UPD_RD: begin
          state <= UPD_WR;
        end

        UPD_WR: begin
          idx   <= idx + CW'(1);
          state <= last_slot ? FINISH : UPD_RD;
        end

        FINISH: begin
          if (fin_fire) begin
            out_valid   <= 1'b1;
            out_hit     <= res_hit;
            out_value   <= res_value;
            out_evicted <= res_evicted;
            out_evkey   <= res_evkey;
            if (do_fill) begin
              used_count <= used_count + CW'(1);
            end
            state <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level properties of the cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lkv_checker import lkv_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              hit,
  input logic [DATA_W-1:0] read_value,
  input logic              evicted,
  input logic [KEY_W-1:0]  evicted_key
);

  // A result beat that is not taken stays valid with its read value and evicted key unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(evicted_key) && $stable(read_value))
    else $error("response beat changed while stalled");

  // One item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an item is in progress");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && evicted))
    else $error("eviction reported on a hit");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> read_value == MISS_VALUE)
    else $error("miss returned a value other than all ones");

  a_no_evict_key: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key reported without an eviction");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .hit         (rsp.hit),
  .read_value  (rsp.read_value),
  .evicted     (rsp.evicted),
  .evicted_key (rsp.evicted_key)
);
